// ===== rtl/fcis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fcis_pkg: shared types and constants of the frame cadence scheduler
// Register indexes, reset values, result kinds and the control struct that
// carries the configuration registers to the scheduling logic.
// ============================================================================
package fcis_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_ENABLE        = 2'd0;
   localparam logic [1:0] CSR_MAX_HOLD      = 2'd1;
   localparam logic [1:0] CSR_BYPASS_STREAK = 2'd2;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 8;

   // Reset values of the configuration registers.
   localparam logic       ENABLE_RESET        = 1'b0;
   localparam logic [3:0] MAX_HOLD_RESET      = 4'd4;
   localparam logic [7:0] BYPASS_STREAK_RESET = 8'd8;

   // The streak of single-refresh frames saturates here.
   localparam logic [7:0] STREAK_MAX = 8'd255;

   typedef enum logic [1:0] {
      KIND_PASS   = 2'd0,
      KIND_STORED = 2'd1,
      KIND_INTERP = 2'd2
   } kind_type;

   typedef struct packed {
      logic       enable;
      logic [3:0] max_hold;
      logic [7:0] bypass_streak;
   } csr_type;

endpackage
`default_nettype wire

// ===== rtl/fcis_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fcis_csr: configuration registers
// Holds enable, max_hold and bypass_streak, written through a plain write port.
// ============================================================================
module fcis_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wen,
   input  wire logic [fcis_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [fcis_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output fcis_pkg::csr_type                         cfg
);

   fcis_pkg::csr_type cfg_ff;
   fcis_pkg::csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            fcis_pkg::CSR_ENABLE:        cfg_in.enable        = csr_wdata[0];
            fcis_pkg::CSR_MAX_HOLD:      cfg_in.max_hold      = csr_wdata[3:0];
            fcis_pkg::CSR_BYPASS_STREAK: cfg_in.bypass_streak = csr_wdata[7:0];
            default:                     cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= fcis_pkg::ENABLE_RESET;
         cfg_ff.max_hold      <= fcis_pkg::MAX_HOLD_RESET;
         cfg_ff.bypass_streak <= fcis_pkg::BYPASS_STREAK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/fcis_sched.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fcis_sched: cadence tracking and step queue
// Holds the scheduling state and computes the result for the offered origin.
// The state advances on every accepted request while scheduling is enabled.
// ============================================================================
module fcis_sched #(
   parameter int ORIGIN_BITS = 24
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  fcis_pkg::csr_type             cfg,
   input  wire logic                     advance,
   input  wire logic [ORIGIN_BITS-1:0]   origin,
   output fcis_pkg::kind_type            res_kind,
   output logic      [ORIGIN_BITS-1:0]   res_frame,
   output logic      [ORIGIN_BITS-1:0]   res_older,
   output logic      [3:0]               res_num,
   output logic      [3:0]               res_den,
   output logic                          res_flow
);

   logic                   seen_any_ff,  seen_any_in;
   logic [ORIGIN_BITS-1:0] last_seen_ff, last_seen_in;
   logic [3:0]             hold_ff,      hold_in;
   logic [7:0]             streak_ff,    streak_in;
   logic                   have_cur_ff,  have_cur_in;
   logic [ORIGIN_BITS-1:0] cur_ff,       cur_in;
   logic [ORIGIN_BITS-1:0] prev_ff,      prev_in;
   logic                   qvalid_ff,    qvalid_in;
   logic [3:0]             qpos_ff,      qpos_in;
   logic [3:0]             qden_ff,      qden_in;

   logic [3:0] max_hold_eff;
   logic [3:0] k;
   logic       novel;

   always_comb begin
      max_hold_eff = (cfg.max_hold == 4'd0) ? 4'd1 : cfg.max_hold;
      novel        = !seen_any_ff || (origin != last_seen_ff);

      // Hold count of the frame that just ended, clamped to 1..max_hold.
      k = hold_ff;
      if (k == 4'd0) begin
         k = 4'd1;
      end
      if (k > max_hold_eff) begin
         k = max_hold_eff;
      end

      seen_any_in  = seen_any_ff;
      last_seen_in = last_seen_ff;
      hold_in      = hold_ff;
      streak_in    = streak_ff;
      have_cur_in  = have_cur_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      qvalid_in    = qvalid_ff;
      qpos_in      = qpos_ff;
      qden_in      = qden_ff;
      res_flow     = 1'b0;

      if (novel) begin
         qvalid_in = 1'b0;
         if (have_cur_ff) begin
            if (k == 4'd1) begin
               if (streak_ff < fcis_pkg::STREAK_MAX) begin
                  streak_in = streak_ff + 8'd1;
               end
            end else begin
               streak_in = 8'd0;
            end
            prev_in   = cur_ff;
            cur_in    = origin;
            qvalid_in = 1'b1;
            if ((streak_in < cfg.bypass_streak) && (k >= 4'd2)) begin
               res_flow = 1'b1;
               qpos_in  = 4'd1;
               qden_in  = k;
            end else begin
               qpos_in = 4'd0;
               qden_in = 4'd0;
            end
         end else begin
            cur_in      = origin;
            have_cur_in = 1'b1;
         end
         last_seen_in = origin;
         seen_any_in  = 1'b1;
         hold_in      = 4'd1;
      end else if (hold_ff < max_hold_eff) begin
         hold_in = hold_ff + 4'd1;
      end

      res_kind  = fcis_pkg::KIND_PASS;
      res_frame = origin;
      res_older = '0;
      res_num   = 4'd0;
      res_den   = 4'd0;

      // Pop one queue entry, or pass the scanout through.
      if (streak_in >= cfg.bypass_streak) begin
         qvalid_in = 1'b0;
         res_flow  = 1'b0;
      end else if (!qvalid_in) begin
         res_flow = 1'b0;
      end else if (qpos_in >= qden_in) begin
         qvalid_in = 1'b0;
         res_flow  = 1'b0;
         res_kind  = fcis_pkg::KIND_STORED;
         res_frame = cur_in;
      end else begin
         res_kind  = fcis_pkg::KIND_INTERP;
         res_frame = cur_in;
         res_older = prev_in;
         res_num   = qpos_in;
         res_den   = qden_in;
         qpos_in   = qpos_in + 4'd1;
      end

      if (!cfg.enable) begin
         res_kind  = fcis_pkg::KIND_PASS;
         res_frame = origin;
         res_older = '0;
         res_num   = 4'd0;
         res_den   = 4'd0;
         res_flow  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_any_ff  <= 1'b0;
         last_seen_ff <= '0;
         hold_ff      <= 4'd0;
         streak_ff    <= 8'd0;
         have_cur_ff  <= 1'b0;
         cur_ff       <= '0;
         prev_ff      <= '0;
         qvalid_ff    <= 1'b0;
         qpos_ff      <= 4'd0;
         qden_ff      <= 4'd0;
      end else if (advance && cfg.enable) begin
         seen_any_ff  <= seen_any_in;
         last_seen_ff <= last_seen_in;
         hold_ff      <= hold_in;
         streak_ff    <= streak_in;
         have_cur_ff  <= have_cur_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         qvalid_ff    <= qvalid_in;
         qpos_ff      <= qpos_in;
         qden_ff      <= qden_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/fcis_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fcis_out_reg: result register
// Holds one result until the consumer takes it and packs it onto the bus.
// ============================================================================
module fcis_out_reg #(
   parameter int ORIGIN_BITS = 24,
   parameter int DATA_BITS   = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  fcis_pkg::kind_type            res_kind,
   input  wire logic [ORIGIN_BITS-1:0]   res_frame,
   input  wire logic [ORIGIN_BITS-1:0]   res_older,
   input  wire logic [3:0]               res_num,
   input  wire logic [3:0]               res_den,
   input  wire logic                     res_flow,
   input  wire logic                     rsp_tready,
   output logic                          rsp_tvalid,
   output logic      [DATA_BITS-1:0]     rsp_tdata,
   output logic      [1:0]               rsp_tuser,
   output logic                          free
);

   localparam int USED_BITS = 2 * ORIGIN_BITS + 9;

   logic                   valid_ff, valid_in;
   fcis_pkg::kind_type     kind_ff;
   logic [ORIGIN_BITS-1:0] frame_ff;
   logic [ORIGIN_BITS-1:0] older_ff;
   logic [3:0]             num_ff;
   logic [3:0]             den_ff;
   logic                   flow_ff;

   // The register can take a new result when empty or being drained now.
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= res_kind;
         frame_ff <= res_frame;
         older_ff <= res_older;
         num_ff   <= res_num;
         den_ff   <= res_den;
         flow_ff  <= res_flow;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {{(DATA_BITS - USED_BITS){1'b0}},
                        flow_ff, den_ff, num_ff, older_ff, frame_ff};

endmodule
`default_nettype wire

// ===== rtl/frame_cadence_interp_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// frame_cadence_interp_scheduler: refresh cadence and interpolation scheduler
// Takes one frame buffer origin per display refresh and tells the display
// path what to show: the scanout itself, the stored novel frame, or an
// interpolation between the two latest novel frames at phase num/den.
// ============================================================================
//
//  Channel | Direction | Handshake              | Contents
//  --------+-----------+------------------------+------------------------------
//  req_    | in        | req_tvalid/req_tready  | tdata: origin
//  rsp_    | out       | rsp_tvalid/rsp_tready  | tdata: frame, older, num, den,
//          |           |                        |        start_flow; tuser: kind
//  csr_    | in        | csr_wen (no wait)      | csr_addr, csr_wdata
//
// Every request is handled combinationally: the scheduling logic reads the
// state registers and the offered origin, and on acceptance writes the new
// state and the result register at the same clock edge. One request can be
// accepted on every cycle while the result register has room. A result that
// is not taken stalls the request side only while the result register is
// full and rsp_tready is low; a request is accepted in the same cycle in
// which the waiting result leaves. Reset is synchronous and clears the
// scheduling state, the result valid flag and the configuration registers to
// their defaults (disabled, max_hold 4, bypass streak 8).
//
module frame_cadence_interp_scheduler #(
   parameter int ORIGIN_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // Bits from lowest: origin, then zero fill.
   input  wire logic [((ORIGIN_BITS + 7) / 8) * 8 - 1:0] req_tdata,

   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // Bits from lowest: frame_origin, older_origin, phase_num, phase_den,
   // start_flow, then zero fill.
   output logic [((2 * ORIGIN_BITS + 9 + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Bits from lowest: kind.
   output logic [1:0]                               rsp_tuser,

   input  wire logic                                csr_wen,
   input  wire logic [fcis_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [fcis_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int RSP_BITS = ((2 * ORIGIN_BITS + 9 + 7) / 8) * 8;

   fcis_pkg::csr_type  cfg;
   fcis_pkg::kind_type res_kind;
   logic [ORIGIN_BITS-1:0] res_frame;
   logic [ORIGIN_BITS-1:0] res_older;
   logic [3:0]             res_num;
   logic [3:0]             res_den;
   logic                   res_flow;
   logic                   out_free;
   logic                   req_accept;

   // A request is taken whenever the result register has room for its result.
   assign req_tready = out_free;
   assign req_accept = req_tvalid && out_free;

   fcis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fcis_sched #(
      .ORIGIN_BITS (ORIGIN_BITS)
   ) u_sched (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (req_accept),
      .origin    (req_tdata[ORIGIN_BITS-1:0]),
      .res_kind  (res_kind),
      .res_frame (res_frame),
      .res_older (res_older),
      .res_num   (res_num),
      .res_den   (res_den),
      .res_flow  (res_flow)
   );

   fcis_out_reg #(
      .ORIGIN_BITS (ORIGIN_BITS),
      .DATA_BITS   (RSP_BITS)
   ) u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .res_kind   (res_kind),
      .res_frame  (res_frame),
      .res_older  (res_older),
      .res_num    (res_num),
      .res_den    (res_den),
      .res_flow   (res_flow),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .free       (out_free)
   );

endmodule
`default_nettype wire
